// ----- hw/rtl/c8x_pkg.sv -----
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types, constants and helpers of the CHIP-8 execute unit.
// ----------------------------------------------------------------------------
package c8x_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W      = $clog2(STACK_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CMD_W   = 5;
    localparam int REG_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 12;
    localparam int INDEX_W = 16;
    localparam int NUM_V   = 16;

    localparam logic [REG_W-1:0] VF_IDX  = 4'hF;
    localparam logic [CMD_W-1:0] CMD_MAX = 5'd20;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_STACK = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        OP_RET     = 5'd0,
        OP_JP      = 5'd1,
        OP_CALL    = 5'd2,
        OP_SE_I    = 5'd3,
        OP_SE_R    = 5'd4,
        OP_SNE_I   = 5'd5,
        OP_SNE_R   = 5'd6,
        OP_LD_I    = 5'd7,
        OP_LD_R    = 5'd8,
        OP_LD_IDX  = 5'd9,
        OP_ADD_I   = 5'd10,
        OP_ADD_R   = 5'd11,
        OP_ADD_IDX = 5'd12,
        OP_OR      = 5'd13,
        OP_AND     = 5'd14,
        OP_XOR     = 5'd15,
        OP_SUB     = 5'd16,
        OP_SUBN    = 5'd17,
        OP_SHR     = 5'd18,
        OP_SHL     = 5'd19,
        OP_BCD     = 5'd20,
        OP_NOP     = 5'd31
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              wr_vx;
        logic              flag_op;
        logic [REG_W-1:0]  x;
        logic [REG_W-1:0]  y;
        logic [BYTE_W-1:0] imm;
        logic [ADDR_W-1:0] addr;
    } c8x_uop_t;

    typedef struct packed {
        logic [1:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } bcd_t;

    // hundreds by compare, tens by reciprocal multiply (205 / 2048)
    function automatic bcd_t bcd_of(input logic [BYTE_W-1:0] v);
        bcd_t       d;
        logic [6:0] rem;
        logic [14:0] prod;
        logic [3:0] tens;
        if (v >= 8'd200)
        begin
            d.hundreds = 2'd2;
            rem        = 7'(v - 8'd200);
        end
        else if (v >= 8'd100)
        begin
            d.hundreds = 2'd1;
            rem        = 7'(v - 8'd100);
        end
        else
        begin
            d.hundreds = 2'd0;
            rem        = v[6:0];
        end
        prod   = 15'(rem) * 15'd205;
        tens   = prod[14:11];
        d.tens = tens;
        d.ones = 4'(rem - 7'({3'b000, tens} * 7'd10));
        return d;
    endfunction

endpackage

// ----- hw/rtl/c8x_if.sv -----
// ----------------------------------------------------------------------------
// c8x_if
// Valid/ready channels for decoded operations in and results out.
// ----------------------------------------------------------------------------
interface c8x_op_if;
    logic                         valid;
    logic                         ready;
    logic [c8x_pkg::CMD_W-1:0]    cmd;
    logic [c8x_pkg::REG_W-1:0]    x;
    logic [c8x_pkg::REG_W-1:0]    y;
    logic [c8x_pkg::BYTE_W-1:0]   imm;
    logic [c8x_pkg::ADDR_W-1:0]   addr;

    modport source (output valid, cmd, x, y, imm, addr, input ready);
    modport sink   (input valid, cmd, x, y, imm, addr, output ready);
endinterface

interface c8x_res_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [c8x_pkg::ADDR_W-1:0]   pc_out;
    logic [c8x_pkg::BYTE_W-1:0]   value_out;
    logic                         flag_out;
    logic [c8x_pkg::INDEX_W-1:0]  index_out;
    logic [1:0]                   digit_hundreds;
    logic [3:0]                   digit_tens;
    logic [3:0]                   digit_ones;

    modport source (output valid, status, pc_out, value_out, flag_out, index_out,
                    digit_hundreds, digit_tens, digit_ones, input ready);
    modport sink   (input valid, status, pc_out, value_out, flag_out, index_out,
                    digit_hundreds, digit_tens, digit_ones, output ready);
endinterface

// ----- hw/rtl/chip8_execute_unit.sv -----
// ----------------------------------------------------------------------------
// chip8_execute_unit
// Executes one decoded CHIP-8 operation per beat and returns one result beat.
//
// A front stage classifies each operation beat and pushes it into a two-entry
// queue; the back stage reads Vx/Vy from the register file, executes and loads
// the result register. One operation per clock is sustained while result beats
// are taken, helped by the write bypass; an operation moves from the queue
// via the execute register to the result register. The return stack
// holds 16 entries; a call on a full stack or a return on an empty one gives
// status 1 and leaves all state unchanged. The program counter only moves on
// jump, call, return or skip, and wraps at 4096.
// ----------------------------------------------------------------------------
module chip8_execute_unit (
    input  logic      clk,
    input  logic      rst_n,
    c8x_op_if.sink    op,
    c8x_res_if.source res
);
    import c8x_pkg::*;

    logic     dec_valid, dec_ready;
    c8x_uop_t dec_uop;
    logic     q_valid, q_ready;
    c8x_uop_t q_uop;

    c8x_front u_front (
        .op        (op),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec_uop   (dec_uop)
    );

    c8x_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (dec_valid),
        .push_ready (dec_ready),
        .push_uop   (dec_uop),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_uop    (q_uop)
    );

    c8x_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_uop   (q_uop),
        .res     (res)
    );

    // bcd digits stay in decimal range
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.digit_tens <= 4'd9) && (res.digit_ones <= 4'd9))
        else $error("bcd digit out of range");

    // bcd digits never encode a value above 255
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.digit_hundreds == 2'd2 |->
            (res.digit_tens < 4'd5) ||
            (res.digit_tens == 4'd5 && res.digit_ones <= 4'd5))
        else $error("bcd value above 255");

    // a stack error is never reported together with bcd digits
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == ST_STACK |->
            res.digit_hundreds == 2'd0 && res.digit_tens == 4'd0 &&
            res.digit_ones == 4'd0)
        else $error("stack error beat carries digits");

    // queue never drops a beat: the front only stalls when the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_ready |-> q_valid)
        else $error("front stalled with empty queue");

endmodule

// ----- hw/rtl/c8x_front.sv -----
// ----------------------------------------------------------------------------
// c8x_front
// Accepts operation beats and classifies them into micro-ops for the queue.
// ----------------------------------------------------------------------------
module c8x_front (
    c8x_op_if.sink              op,
    output logic                dec_valid,
    input  logic                dec_ready,
    output c8x_pkg::c8x_uop_t   dec_uop
);
    import c8x_pkg::*;

    assign dec_valid = op.valid;
    assign op.ready  = dec_ready;

    always_comb
    begin
        dec_uop.x    = op.x;
        dec_uop.y    = op.y;
        dec_uop.imm  = op.imm;
        dec_uop.addr = op.addr;
        // codes past the last operation do nothing
        if (op.cmd <= CMD_MAX)
            dec_uop.op = op_t'(op.cmd);
        else
            dec_uop.op = OP_NOP;

        dec_uop.wr_vx   = 1'b0;
        dec_uop.flag_op = 1'b0;
        case (dec_uop.op)
            OP_LD_I, OP_LD_R, OP_ADD_I, OP_OR, OP_AND, OP_XOR:
            begin
                dec_uop.wr_vx = 1'b1;
            end
            OP_ADD_R, OP_SUB, OP_SUBN, OP_SHR, OP_SHL:
            begin
                dec_uop.wr_vx   = 1'b1;
                dec_uop.flag_op = 1'b1;
            end
            default:
            begin
                dec_uop.wr_vx   = 1'b0;
                dec_uop.flag_op = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/c8x_queue.sv -----
// ----------------------------------------------------------------------------
// c8x_queue
// Short micro-op queue between the front and the back.
// ----------------------------------------------------------------------------
module c8x_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  c8x_pkg::c8x_uop_t   push_uop,
    output logic                pop_valid,
    input  logic                pop_ready,
    output c8x_pkg::c8x_uop_t   pop_uop
);
    import c8x_pkg::*;

    c8x_uop_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_uop    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_uop;
    end

endmodule

// ----- hw/rtl/c8x_back.sv -----
// ----------------------------------------------------------------------------
// c8x_back
// Execute stage: register file, pc, index, return stack and result register.
// ----------------------------------------------------------------------------
module c8x_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  c8x_pkg::c8x_uop_t   q_uop,
    c8x_res_if.source           res
);
    import c8x_pkg::*;

    // V0..VE live in a memory, VF in its own register
    logic [BYTE_W-1:0]  vmem [NUM_V];
    logic [NUM_V-1:0]   vvld_reg, vvld_next;
    logic [BYTE_W-1:0]  vf_reg, vf_next;
    logic               byp_vld_reg;
    logic [REG_W-1:0]   byp_addr_reg;
    logic [BYTE_W-1:0]  byp_data_reg;

    logic [ADDR_W-1:0]  pc_reg, pc_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0]  stack_reg [STACK_DEPTH];

    logic               e_vld_reg;
    c8x_uop_t           e_uop_reg;
    logic [BYTE_W-1:0]  rdx_reg, rdy_reg;

    logic               res_vld_reg;
    logic               status_reg;
    logic [ADDR_W-1:0]  pc_out_reg;
    logic [BYTE_W-1:0]  value_reg;
    logic               flag_reg;
    logic [INDEX_W-1:0] index_out_reg;
    bcd_t               bcd_reg;

    logic               e_fire, pop, mem_wr;
    logic [BYTE_W-1:0]  vx, vy, res_val;
    logic [BYTE_W:0]    sum;
    logic               flag, status, push;
    logic [SP_W-1:0]    sp_dec;
    bcd_t               bcd;

    assign e_fire  = e_vld_reg && (!res_vld_reg || res.ready);
    assign q_ready = !e_vld_reg || e_fire;
    assign pop     = q_valid && q_ready;
    assign sp_dec  = sp_reg - 1'b1;

    // operand read with bypass of the write that landed as the read was taken
    always_comb
    begin
        if (e_uop_reg.x == VF_IDX)
            vx = vf_reg;
        else if (byp_vld_reg && byp_addr_reg == e_uop_reg.x)
            vx = byp_data_reg;
        else if (vvld_reg[e_uop_reg.x])
            vx = rdx_reg;
        else
            vx = '0;

        if (e_uop_reg.y == VF_IDX)
            vy = vf_reg;
        else if (byp_vld_reg && byp_addr_reg == e_uop_reg.y)
            vy = byp_data_reg;
        else if (vvld_reg[e_uop_reg.y])
            vy = rdy_reg;
        else
            vy = '0;
    end

    always_comb
    begin
        pc_next  = pc_reg;
        sp_next  = sp_reg;
        idx_next = idx_reg;
        status   = ST_OK;
        push     = 1'b0;
        res_val  = '0;
        flag     = 1'b0;
        sum      = {1'b0, vx} + {1'b0, vy};
        bcd      = '0;
        case (e_uop_reg.op)
            OP_RET:
            begin
                if (sp_reg == '0)
                    status = ST_STACK;
                else
                begin
                    sp_next = sp_dec;
                    pc_next = stack_reg[sp_dec[SIDX_W-1:0]];
                end
            end
            OP_JP:
            begin
                pc_next = e_uop_reg.addr;
            end
            OP_CALL:
            begin
                if (sp_reg == SP_W'(STACK_DEPTH))
                    status = ST_STACK;
                else
                begin
                    push    = 1'b1;
                    sp_next = sp_reg + 1'b1;
                    pc_next = e_uop_reg.addr;
                end
            end
            OP_SE_I:
            begin
                if (vx == e_uop_reg.imm)
                    pc_next = pc_reg + 12'd2;
            end
            OP_SE_R:
            begin
                if (vx == vy)
                    pc_next = pc_reg + 12'd2;
            end
            OP_SNE_I:
            begin
                if (vx != e_uop_reg.imm)
                    pc_next = pc_reg + 12'd2;
            end
            OP_SNE_R:
            begin
                if (vx != vy)
                    pc_next = pc_reg + 12'd2;
            end
            OP_LD_I:    res_val = e_uop_reg.imm;
            OP_LD_R:    res_val = vy;
            OP_LD_IDX:  idx_next = {4'h0, e_uop_reg.addr};
            OP_ADD_I:   res_val = vx + e_uop_reg.imm;
            OP_ADD_R:
            begin
                res_val = sum[BYTE_W-1:0];
                flag    = sum[BYTE_W];
            end
            OP_ADD_IDX: idx_next = idx_reg + {8'h00, vx};
            OP_OR:      res_val = vx | vy;
            OP_AND:     res_val = vx & vy;
            OP_XOR:     res_val = vx ^ vy;
            OP_SUB:
            begin
                res_val = vx - vy;
                flag    = (vx > vy);
            end
            OP_SUBN:
            begin
                res_val = vy - vx;
                flag    = (vy > vx);
            end
            OP_SHR:
            begin
                res_val = {1'b0, vx[BYTE_W-1:1]};
                flag    = vx[0];
            end
            OP_SHL:
            begin
                res_val = {vx[BYTE_W-2:0], 1'b0};
                flag    = vx[BYTE_W-1];
            end
            OP_BCD:     bcd = bcd_of(vx);
            default:
            begin
                res_val = '0;
            end
        endcase

        // destination write wins over the flag when x is VF
        vf_next = vf_reg;
        if (e_uop_reg.wr_vx && e_uop_reg.x == VF_IDX)
            vf_next = res_val;
        else if (e_uop_reg.flag_op)
            vf_next = {7'b0, flag};

        mem_wr    = e_uop_reg.wr_vx && (e_uop_reg.x != VF_IDX);
        vvld_next = vvld_reg;
        if (mem_wr)
            vvld_next[e_uop_reg.x] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg    <= 1'b0;
            res_vld_reg  <= 1'b0;
            pc_reg       <= '0;
            sp_reg       <= '0;
            idx_reg      <= '0;
            vf_reg       <= '0;
            vvld_reg     <= '0;
            byp_vld_reg  <= 1'b0;
            byp_addr_reg <= '0;
            byp_data_reg <= '0;
        end
        else
        begin
            if (q_ready)
                e_vld_reg <= q_valid;
            if (e_fire)
                res_vld_reg <= 1'b1;
            else if (res.ready)
                res_vld_reg <= 1'b0;
            if (e_fire)
            begin
                pc_reg   <= pc_next;
                sp_reg   <= sp_next;
                idx_reg  <= idx_next;
                vf_reg   <= vf_next;
                vvld_reg <= vvld_next;
                if (mem_wr)
                begin
                    byp_vld_reg  <= 1'b1;
                    byp_addr_reg <= e_uop_reg.x;
                    byp_data_reg <= res_val;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e_uop_reg <= q_uop;
            rdx_reg   <= vmem[q_uop.x];
            rdy_reg   <= vmem[q_uop.y];
        end
        if (e_fire && mem_wr)
            vmem[e_uop_reg.x] <= res_val;
        if (e_fire && push)
            stack_reg[sp_reg[SIDX_W-1:0]] <= pc_reg;
        if (e_fire)
        begin
            status_reg    <= status;
            pc_out_reg    <= pc_next;
            value_reg     <= e_uop_reg.wr_vx ? res_val : vx;
            flag_reg      <= e_uop_reg.flag_op ? flag : vf_next[0];
            index_out_reg <= idx_next;
            bcd_reg       <= bcd;
        end
    end

    assign res.valid          = res_vld_reg;
    assign res.status         = status_reg;
    assign res.pc_out         = pc_out_reg;
    assign res.value_out      = value_reg;
    assign res.flag_out       = flag_reg;
    assign res.index_out      = index_out_reg;
    assign res.digit_hundreds = bcd_reg.hundreds;
    assign res.digit_tens     = bcd_reg.tens;
    assign res.digit_ones     = bcd_reg.ones;

endmodule
